>>> rtl/ptss_pkg.sv
// shared types and constants for the pan/tilt servo slew controller
// no dependencies; used by ptss_ctrl, ptss_datapath and the top level

package ptss_pkg;

    // default angle resolution: fractional bits of a degree
    localparam int ANGLE_FRAC_BITS_DEF = 8;

    // field widths
    localparam int MS_W    = 10;
    localparam int STICK_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PULSE_W = 12;

    // item kinds
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_CTRL = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPEED_NORMAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPEED_PRECISE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_RATE_NORMAL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_RATE_PRECISE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT_MS      = 3'd4;

    // configuration reset values
    localparam logic [CFG_W-1:0] RST_TARGET_SPEED_NORMAL  = 16'd11520;
    localparam logic [CFG_W-1:0] RST_TARGET_SPEED_PRECISE = 16'd2560;
    localparam logic [CFG_W-1:0] RST_SLEW_RATE_NORMAL     = 16'd15360;
    localparam logic [CFG_W-1:0] RST_SLEW_RATE_PRECISE    = 16'd154;
    localparam logic [CFG_W-1:0] RST_LINK_TIMEOUT_MS      = 16'd250;

    // travel limits and home, whole degrees
    localparam int PAN_LO_DEG  = 15;
    localparam int PAN_HI_DEG  = 165;
    localparam int TILT_LO_DEG = 20;
    localparam int TILT_HI_DEG = 160;
    localparam int HOME_DEG    = 90;

    // pulse mapping: 500 + round((a - lo) * 2000 / span)
    localparam int PULSE_MIN      = 500;
    localparam int PULSE_SCALE    = 4000;   // twice the 2000 us span, for rounding
    localparam int PAN_ROUND_OFS  = 150;    // half the doubled pan span, whole degrees
    localparam int TILT_ROUND_OFS = 140;

    // shared multiplier
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // stick squaring keeps Q1.15
    localparam int SQ_SHIFT = 15;
    // x / (1000 << 15): drop 15 + 3 bits, then exact reciprocal of 125
    localparam int MS_SHIFT   = 18;
    localparam int STEP_SHIFT = 3;
    localparam int RECIP_125  = 17179870;   // ceil(2^31 / 125)
    localparam int RECIP_125_SHIFT = 31;

    // pulse divide: pan by 300 = 4 * 75, tilt by 280 = 8 * 35
    localparam int PAN_PRE_SHIFT    = 2;
    localparam int TILT_PRE_SHIFT   = 3;
    localparam int PAN_PULSE_RECIP  = 447393;   // ceil(2^25 / 75)
    localparam int TILT_PULSE_RECIP = 958699;   // ceil(2^25 / 35)
    localparam int PULSE_RECIP_SHIFT = 25;

    // datapath operations
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_START,
        OP_SQ,
        OP_SPEED,
        OP_MS,
        OP_DIV,
        OP_GOAL,
        OP_STEP,
        OP_SLEW,
        OP_PUL_A,
        OP_PUL_B
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   tilt;      // axis select for per-axis operations
        logic   in_load;   // capture the incoming request fields
    } dp_cmd_t;

endpackage

>>> rtl/pan_tilt_servo_slew_controller_unit.sv
// top level of the pan/tilt servo slew controller: ports, request packing, result register
// depends on ptss_pkg, ptss_ctrl and ptss_datapath
//
// channel   direction  handshake                 contents
// s_        in         s_tvalid / s_tready       tick or control request (kind in s_tuser)
// m_        out        m_tvalid / m_tready       servo pulse widths and status flags
// cfg_      in         cfg_valid / cfg_ready     register index and 16 bit value
//
// a tick with nonzero elapsed time steps through the sequencer states to a result in the
// output register, after which the next request is taken; a control request only loads
// its fields and a zero elapsed tick is taken while idle, neither giving a result
// the tick sequence is set by the single shared multiplier, used fourteen times per tick
// synchronous active-low reset restores home angles, default rates and a dead link
// a waiting result does not block the next request; the sequencer only stalls at the end
// of a tick while the previous result has not been taken

module pan_tilt_servo_slew_controller_unit #(
    parameter int ANGLE_FRAC_BITS = ptss_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // elapsed_ms[9:0], precise_flag[10], recenter_flag[11],
                                   // pan_stick[27:12], tilt_stick[43:28], zero[47:44]
    input  logic [0:0]  s_tuser,   // func[0]: 0 tick, 1 control

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pan_pulse_us[11:0], tilt_pulse_us[23:12],
                                   // blink_mode[24], link_alive[25], zero[31:26]

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [ptss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptss_pkg::CFG_W-1:0]     cfg_data
);

    ptss_pkg::dp_cmd_t cmd;

    logic                          out_free;
    logic                          out_push;
    logic [ptss_pkg::PULSE_W-1:0]  pan_pulse, tilt_pulse;
    logic                          blink_mode, link_alive;

    // result register
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    // the config registers take a write on any cycle
    assign cfg_ready = 1'b1;

    // result slot is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    ptss_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_func    (s_tuser[0]),
        .in_ms_zero (s_tdata[9:0] == '0),
        .out_free   (out_free),
        .in_ready   (s_tready),
        .out_push   (out_push),
        .cmd        (cmd)
    );

    ptss_datapath #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_ms       (s_tdata[9:0]),
        .in_precise  (s_tdata[10]),
        .in_recenter (s_tdata[11]),
        .in_pan      ($signed(s_tdata[27:12])),
        .in_tilt     ($signed(s_tdata[43:28])),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pan_pulse   (pan_pulse),
        .tilt_pulse  (tilt_pulse),
        .blink_mode  (blink_mode),
        .link_alive  (link_alive)
    );

    // output handshake state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // result payload, packed from the lowest field up
    always_ff @(posedge aclk) begin
        if (out_push) begin
            m_tdata_reg <= {6'd0, link_alive, blink_mode, tilt_pulse, pan_pulse};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/ptss_ctrl.sv
// sequencer for the pan/tilt slew controller: accepts requests and steps the datapath
// depends on ptss_pkg

module ptss_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              in_func,
    input  logic              in_ms_zero,
    input  logic              out_free,
    output logic              in_ready,
    output logic              out_push,
    output ptss_pkg::dp_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_START,
        S_P_SQ,
        S_P_SPEED,
        S_P_MS,
        S_P_DIV,
        S_P_GOAL,
        S_T_SQ,
        S_T_SPEED,
        S_T_MS,
        S_T_DIV,
        S_T_GOAL,
        S_STEP,
        S_STEP_DIV,
        S_SLEW,
        S_PP_A,
        S_PP_B,
        S_TP_A,
        S_TP_B,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   ready_reg;
    logic   accept;

    assign accept   = in_valid && ready_reg;
    assign in_ready = ready_reg;
    assign out_push = (state_reg == S_FINISH) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (in_func == ptss_pkg::FUNC_CTRL) begin
                            state_reg <= S_LOAD;
                            ready_reg <= 1'b0;
                        end else if (!in_ms_zero) begin
                            state_reg <= S_START;
                            ready_reg <= 1'b0;
                        end
                    end
                end
                S_LOAD: begin
                    state_reg <= S_IDLE;
                    ready_reg <= 1'b1;
                end
                S_START:    state_reg <= S_P_SQ;
                S_P_SQ:     state_reg <= S_P_SPEED;
                S_P_SPEED:  state_reg <= S_P_MS;
                S_P_MS:     state_reg <= S_P_DIV;
                S_P_DIV:    state_reg <= S_P_GOAL;
                S_P_GOAL:   state_reg <= S_T_SQ;
                S_T_SQ:     state_reg <= S_T_SPEED;
                S_T_SPEED:  state_reg <= S_T_MS;
                S_T_MS:     state_reg <= S_T_DIV;
                S_T_DIV:    state_reg <= S_T_GOAL;
                S_T_GOAL:   state_reg <= S_STEP;
                S_STEP:     state_reg <= S_STEP_DIV;
                S_STEP_DIV: state_reg <= S_SLEW;
                S_SLEW:     state_reg <= S_PP_A;
                S_PP_A:     state_reg <= S_PP_B;
                S_PP_B:     state_reg <= S_TP_A;
                S_TP_A:     state_reg <= S_TP_B;
                S_TP_B:     state_reg <= S_FINISH;
                S_FINISH: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    // operation for the current step
    always_comb begin
        cmd.in_load = accept;
        cmd.tilt    = 1'b0;
        unique case (state_reg)
            S_LOAD:     cmd.op = ptss_pkg::OP_LOAD;
            S_START:    cmd.op = ptss_pkg::OP_START;
            S_P_SQ:     cmd.op = ptss_pkg::OP_SQ;
            S_P_SPEED:  cmd.op = ptss_pkg::OP_SPEED;
            S_P_MS:     cmd.op = ptss_pkg::OP_MS;
            S_P_DIV:    cmd.op = ptss_pkg::OP_DIV;
            S_P_GOAL:   cmd.op = ptss_pkg::OP_GOAL;
            S_T_SQ: begin
                cmd.op   = ptss_pkg::OP_SQ;
                cmd.tilt = 1'b1;
            end
            S_T_SPEED: begin
                cmd.op   = ptss_pkg::OP_SPEED;
                cmd.tilt = 1'b1;
            end
            S_T_MS: begin
                cmd.op   = ptss_pkg::OP_MS;
                cmd.tilt = 1'b1;
            end
            S_T_DIV: begin
                cmd.op   = ptss_pkg::OP_DIV;
                cmd.tilt = 1'b1;
            end
            S_T_GOAL: begin
                cmd.op   = ptss_pkg::OP_GOAL;
                cmd.tilt = 1'b1;
            end
            S_STEP:     cmd.op = ptss_pkg::OP_STEP;
            S_STEP_DIV: cmd.op = ptss_pkg::OP_DIV;
            S_SLEW:     cmd.op = ptss_pkg::OP_SLEW;
            S_PP_A:     cmd.op = ptss_pkg::OP_PUL_A;
            S_PP_B:     cmd.op = ptss_pkg::OP_PUL_B;
            S_TP_A: begin
                cmd.op   = ptss_pkg::OP_PUL_A;
                cmd.tilt = 1'b1;
            end
            S_TP_B: begin
                cmd.op   = ptss_pkg::OP_PUL_B;
                cmd.tilt = 1'b1;
            end
            default:    cmd.op = ptss_pkg::OP_IDLE;
        endcase
    end

endmodule

>>> rtl/ptss_datapath.sv
// datapath of the pan/tilt slew controller: state, config registers, one shared multiplier
// depends on ptss_pkg; driven by ptss_ctrl commands

module ptss_datapath #(
    parameter int ANGLE_FRAC_BITS = ptss_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ptss_pkg::dp_cmd_t                    cmd,
    input  logic [ptss_pkg::MS_W-1:0]            in_ms,
    input  logic                                 in_precise,
    input  logic                                 in_recenter,
    input  logic signed [ptss_pkg::STICK_W-1:0]  in_pan,
    input  logic signed [ptss_pkg::STICK_W-1:0]  in_tilt,
    input  logic                                 cfg_we,
    input  logic [ptss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ptss_pkg::CFG_W-1:0]           cfg_data,
    output logic [ptss_pkg::PULSE_W-1:0]         pan_pulse,
    output logic [ptss_pkg::PULSE_W-1:0]         tilt_pulse,
    output logic                                 blink_mode,
    output logic                                 link_alive
);

    localparam int ANGLE_W = 8 + ANGLE_FRAC_BITS;
    localparam int DELTA_W = 18;
    localparam int SUM_W   = ((ANGLE_W > DELTA_W) ? ANGLE_W : DELTA_W) + 2;
    localparam int Z_W     = 21;
    localparam int STW     = ptss_pkg::STICK_W;
    localparam int CW      = ptss_pkg::CFG_W;

    localparam logic [ANGLE_W-1:0] PAN_LO_A  = ANGLE_W'(ptss_pkg::PAN_LO_DEG) << ANGLE_FRAC_BITS;
    localparam logic [ANGLE_W-1:0] PAN_HI_A  = ANGLE_W'(ptss_pkg::PAN_HI_DEG) << ANGLE_FRAC_BITS;
    localparam logic [ANGLE_W-1:0] TILT_LO_A = ANGLE_W'(ptss_pkg::TILT_LO_DEG) << ANGLE_FRAC_BITS;
    localparam logic [ANGLE_W-1:0] TILT_HI_A = ANGLE_W'(ptss_pkg::TILT_HI_DEG) << ANGLE_FRAC_BITS;
    localparam logic [ANGLE_W-1:0] HOME_A    = ANGLE_W'(ptss_pkg::HOME_DEG) << ANGLE_FRAC_BITS;

    // configuration
    logic [CW-1:0] tsn_reg, tsp_reg, srn_reg, srp_reg, tmo_reg;

    // captured request
    logic [ptss_pkg::MS_W-1:0] ms_reg;
    logic                      in_precise_reg, in_recenter_reg;
    logic signed [STW-1:0]     in_pan_reg, in_tilt_reg;

    // controller state
    logic                  precise_reg, recenter_reg, ever_reg;
    logic [15:0]           age_reg;
    logic signed [STW-1:0] pan_rate_reg, tilt_rate_reg;
    logic [ANGLE_W-1:0]    pan_goal_reg, tilt_goal_reg, pan_angle_reg, tilt_angle_reg;

    // work registers
    logic [ptss_pkg::MUL_A_W-1:0] acc_reg, acc_next;
    logic [ptss_pkg::PULSE_W-1:0] pan_pulse_reg, tilt_pulse_reg;

    // selections
    logic signed [STW-1:0]        stick_sel;
    logic [STW-1:0]               stick_mag;
    logic [CW-1:0]                speed_sel, slew_sel;
    logic [ANGLE_W-1:0]           angle_sel, goal_sel, lo_sel, hi_sel;

    logic [ptss_pkg::MUL_A_W-1:0] mul_a;
    logic [ptss_pkg::MUL_B_W-1:0] mul_b;
    logic [ptss_pkg::PROD_W-1:0]  mul_prod;

    logic [16:0]                  age_sum;
    logic [15:0]                  age_sat;
    logic                         timed_out;

    logic signed [SUM_W-1:0]      goal_ext, delta_ext, goal_sum, lo_ext, hi_ext;
    logic [ANGLE_W-1:0]           goal_clamped;

    logic signed [SUM_W-1:0]      step_ext;
    logic [ANGLE_W-1:0]           pan_slewed, tilt_slewed;

    logic [Z_W-1:0]               pul_z;
    logic [ptss_pkg::PULSE_W-1:0] pulse_val;

    // move cur toward goal by at most step, never past it
    function automatic logic [ANGLE_W-1:0] slew_to(input logic [ANGLE_W-1:0] cur,
                                                  input logic [ANGLE_W-1:0] goal,
                                                  input logic signed [SUM_W-1:0] step);
        logic signed [SUM_W-1:0] c, g, up, dn;
        logic [ANGLE_W-1:0]      res;
        c  = $signed(SUM_W'(cur));
        g  = $signed(SUM_W'(goal));
        up = c + step;
        dn = c - step;
        if (g > c) begin
            res = (up < g) ? ANGLE_W'(up) : goal;
        end else if (g < c) begin
            res = (dn > g) ? ANGLE_W'(dn) : goal;
        end else begin
            res = cur;
        end
        return res;
    endfunction

    assign stick_sel = cmd.tilt ? tilt_rate_reg : pan_rate_reg;
    assign stick_mag = stick_sel[STW-1] ? (~stick_sel + STW'(1)) : stick_sel;
    assign speed_sel = precise_reg ? tsp_reg : tsn_reg;
    assign slew_sel  = precise_reg ? srp_reg : srn_reg;
    assign angle_sel = cmd.tilt ? tilt_angle_reg : pan_angle_reg;
    assign goal_sel  = cmd.tilt ? tilt_goal_reg : pan_goal_reg;
    assign lo_sel    = cmd.tilt ? TILT_LO_A : PAN_LO_A;
    assign hi_sel    = cmd.tilt ? TILT_HI_A : PAN_HI_A;

    // shared multiplier operands
    always_comb begin
        case (cmd.op)
            ptss_pkg::OP_SQ: begin
                mul_a = ptss_pkg::MUL_A_W'(stick_mag);
                mul_b = ptss_pkg::MUL_B_W'(stick_mag);
            end
            ptss_pkg::OP_SPEED: begin
                mul_a = acc_reg;
                mul_b = ptss_pkg::MUL_B_W'(speed_sel);
            end
            ptss_pkg::OP_MS: begin
                mul_a = acc_reg;
                mul_b = ptss_pkg::MUL_B_W'(ms_reg);
            end
            ptss_pkg::OP_DIV: begin
                mul_a = acc_reg;
                mul_b = ptss_pkg::MUL_B_W'(ptss_pkg::RECIP_125);
            end
            ptss_pkg::OP_STEP: begin
                mul_a = ptss_pkg::MUL_A_W'(slew_sel);
                mul_b = ptss_pkg::MUL_B_W'(ms_reg);
            end
            ptss_pkg::OP_PUL_A: begin
                mul_a = ptss_pkg::MUL_A_W'(angle_sel - lo_sel);
                mul_b = ptss_pkg::MUL_B_W'(ptss_pkg::PULSE_SCALE);
            end
            ptss_pkg::OP_PUL_B: begin
                mul_a = acc_reg;
                mul_b = cmd.tilt ? ptss_pkg::MUL_B_W'(ptss_pkg::TILT_PULSE_RECIP)
                                 : ptss_pkg::MUL_B_W'(ptss_pkg::PAN_PULSE_RECIP);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = ptss_pkg::PROD_W'(mul_a) * ptss_pkg::PROD_W'(mul_b);

    // rounding offset added after dropping the angle fraction
    assign pul_z = Z_W'(mul_prod >> ANGLE_FRAC_BITS)
                 + (cmd.tilt ? Z_W'(ptss_pkg::TILT_ROUND_OFS) : Z_W'(ptss_pkg::PAN_ROUND_OFS));
    assign pulse_val = ptss_pkg::PULSE_W'(mul_prod >> ptss_pkg::PULSE_RECIP_SHIFT)
                     + ptss_pkg::PULSE_W'(ptss_pkg::PULSE_MIN);

    always_comb begin
        case (cmd.op)
            ptss_pkg::OP_SQ:    acc_next = ptss_pkg::MUL_A_W'(mul_prod >> ptss_pkg::SQ_SHIFT);
            ptss_pkg::OP_SPEED: acc_next = mul_prod[ptss_pkg::MUL_A_W-1:0];
            ptss_pkg::OP_MS:    acc_next = ptss_pkg::MUL_A_W'(mul_prod >> ptss_pkg::MS_SHIFT);
            ptss_pkg::OP_DIV:   acc_next = ptss_pkg::MUL_A_W'(mul_prod >> ptss_pkg::RECIP_125_SHIFT);
            ptss_pkg::OP_STEP:  acc_next = ptss_pkg::MUL_A_W'(mul_prod >> ptss_pkg::STEP_SHIFT);
            ptss_pkg::OP_PUL_A: acc_next = cmd.tilt
                                ? ptss_pkg::MUL_A_W'(pul_z >> ptss_pkg::TILT_PRE_SHIFT)
                                : ptss_pkg::MUL_A_W'(pul_z >> ptss_pkg::PAN_PRE_SHIFT);
            default:            acc_next = acc_reg;
        endcase
    end

    // link age, saturating at 16 bits
    assign age_sum   = {1'b0, age_reg} + 17'(ms_reg);
    assign age_sat   = age_sum[16] ? 16'hFFFF : age_sum[15:0];
    assign timed_out = !ever_reg || (age_sat > tmo_reg);

    // goal integration with sign-magnitude delta, then clamp
    assign goal_ext  = $signed(SUM_W'(goal_sel));
    assign delta_ext = $signed(SUM_W'(acc_reg[DELTA_W-1:0]));
    assign goal_sum  = stick_sel[STW-1] ? (goal_ext - delta_ext) : (goal_ext + delta_ext);
    assign lo_ext    = $signed(SUM_W'(lo_sel));
    assign hi_ext    = $signed(SUM_W'(hi_sel));
    assign goal_clamped = (goal_sum < lo_ext) ? lo_sel :
                          (goal_sum > hi_ext) ? hi_sel : ANGLE_W'(goal_sum);

    assign step_ext    = $signed(SUM_W'(acc_reg[DELTA_W-1:0]));
    assign pan_slewed  = slew_to(pan_angle_reg, pan_goal_reg, step_ext);
    assign tilt_slewed = slew_to(tilt_angle_reg, tilt_goal_reg, step_ext);

    // config and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tsn_reg        <= ptss_pkg::RST_TARGET_SPEED_NORMAL;
            tsp_reg        <= ptss_pkg::RST_TARGET_SPEED_PRECISE;
            srn_reg        <= ptss_pkg::RST_SLEW_RATE_NORMAL;
            srp_reg        <= ptss_pkg::RST_SLEW_RATE_PRECISE;
            tmo_reg        <= ptss_pkg::RST_LINK_TIMEOUT_MS;
            precise_reg    <= 1'b0;
            recenter_reg   <= 1'b0;
            ever_reg       <= 1'b0;
            age_reg        <= '0;
            pan_rate_reg   <= '0;
            tilt_rate_reg  <= '0;
            pan_goal_reg   <= HOME_A;
            tilt_goal_reg  <= HOME_A;
            pan_angle_reg  <= HOME_A;
            tilt_angle_reg <= HOME_A;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    ptss_pkg::CFG_TARGET_SPEED_NORMAL:  tsn_reg <= cfg_data;
                    ptss_pkg::CFG_TARGET_SPEED_PRECISE: tsp_reg <= cfg_data;
                    ptss_pkg::CFG_SLEW_RATE_NORMAL:     srn_reg <= cfg_data;
                    ptss_pkg::CFG_SLEW_RATE_PRECISE:    srp_reg <= cfg_data;
                    ptss_pkg::CFG_LINK_TIMEOUT_MS:      tmo_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (cmd.op)
                ptss_pkg::OP_LOAD: begin
                    precise_reg   <= in_precise_reg;
                    recenter_reg  <= in_recenter_reg;
                    pan_rate_reg  <= in_pan_reg;
                    tilt_rate_reg <= in_tilt_reg;
                    ever_reg      <= 1'b1;
                    age_reg       <= '0;
                end
                ptss_pkg::OP_START: begin
                    age_reg <= age_sat;
                    if (timed_out) begin
                        pan_rate_reg  <= '0;
                        tilt_rate_reg <= '0;
                        precise_reg   <= 1'b0;
                        recenter_reg  <= 1'b0;
                    end else if (recenter_reg) begin
                        pan_goal_reg  <= HOME_A;
                        tilt_goal_reg <= HOME_A;
                        recenter_reg  <= 1'b0;
                    end
                end
                ptss_pkg::OP_GOAL: begin
                    if (cmd.tilt) begin
                        tilt_goal_reg <= goal_clamped;
                    end else begin
                        pan_goal_reg <= goal_clamped;
                    end
                end
                ptss_pkg::OP_SLEW: begin
                    pan_angle_reg  <= pan_slewed;
                    tilt_angle_reg <= tilt_slewed;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            ms_reg          <= in_ms;
            in_precise_reg  <= in_precise;
            in_recenter_reg <= in_recenter;
            in_pan_reg      <= in_pan;
            in_tilt_reg     <= in_tilt;
        end
        acc_reg <= acc_next;
        if (cmd.op == ptss_pkg::OP_PUL_B) begin
            if (cmd.tilt) begin
                tilt_pulse_reg <= pulse_val;
            end else begin
                pan_pulse_reg <= pulse_val;
            end
        end
    end

    assign pan_pulse  = pan_pulse_reg;
    assign tilt_pulse = tilt_pulse_reg;
    assign blink_mode = precise_reg;
    assign link_alive = ever_reg && (age_reg <= tmo_reg);

endmodule
